### hw/rtl/alm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the array linked list manager.
// Used by alm_ctrl, alm_datapath and array_linked_list_manager; no dependencies.
package alm_pkg;

  localparam int ALM_CAPACITY    = 64;
  localparam int ALM_VALUE_WIDTH = 32;

  localparam int CMD_W    = 3;
  localparam int WHERE_W  = 6;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT_BEFORE = 3'd0,
    CMD_PUSH_FRONT    = 3'd1,
    CMD_PUSH_BACK     = 3'd2,
    CMD_DELETE        = 3'd3,
    CMD_POP_FRONT     = 3'd4,
    CMD_POP_BACK      = 3'd5,
    CMD_FIND_POSITION = 3'd6,
    CMD_READ_SLOT     = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    DP_NOP       = 4'd0,
    DP_CLEAR     = 4'd1,
    DP_LOAD      = 4'd2,
    DP_INS_RD    = 4'd3,
    DP_INS_WR1   = 4'd4,
    DP_INS_WR2   = 4'd5,
    DP_REM_RD    = 4'd6,
    DP_REM_WR1   = 4'd7,
    DP_REM_WR2   = 4'd8,
    DP_WALK_STEP = 4'd9,
    DP_WALK_LAST = 4'd10,
    DP_READ_RD   = 4'd11
  } dp_op_t;

  typedef enum logic [2:0] {
    RES_ERR      = 3'd0,
    RES_INSERT   = 3'd1,
    RES_REMOVE   = 3'd2,
    RES_FIND     = 3'd3,
    RES_READ     = 3'd4,
    RES_SENTINEL = 3'd5
  } res_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     out_load;
    res_sel_t res;
    status_t  status;
  } dp_cmd_t;

  typedef struct packed {
    logic where_bad;
    logic where_zero;
    logic where_ge_count;
    logic count_zero;
    logic count_max;
    logic free_empty;
    logic pos_zero;
    logic use_q;
    logic steps_zero;
    logic clr_last;
  } dp_stat_t;

endpackage

### hw/rtl/alm_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the array linked list manager.
// Depends on alm_pkg; drives alm_datapath through dp_cmd_t and reads dp_stat_t.
module alm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  alm_pkg::cmd_t     in_cmd,
  output logic              out_valid,
  input  logic              out_stall,
  input  alm_pkg::dp_stat_t stat,
  output alm_pkg::dp_cmd_t  cmd
);
  import alm_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_INS_RD   = 11'b00000000100,
    S_INS_CHK  = 11'b00000001000,
    S_INS_WR   = 11'b00000010000,
    S_REM_RD   = 11'b00000100000,
    S_REM_CHK  = 11'b00001000000,
    S_REM_WR   = 11'b00010000000,
    S_WALK     = 11'b00100000000,
    S_READ_RD  = 11'b01000000000,
    S_READ_CHK = 11'b10000000000
  } state_t;

  state_t   state_r, state_nxt;
  logic     emit_r, emit_nxt;
  res_sel_t res_r, res_nxt;
  status_t  status_r, status_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     out_free;
  logic     accept;
  logic     idle_slot;

  assign out_free  = !out_valid_r || !out_stall;
  assign idle_slot = (state_r == S_IDLE) && (!emit_r || out_free);
  assign in_stall  = !idle_slot;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    emit_nxt      = emit_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = DP_NOP;
    cmd.out_load  = 1'b0;
    cmd.res       = res_r;
    cmd.status    = status_r;

    case (state_r)
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // finished word waits here for the output register
        if (emit_r && out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          emit_nxt      = 1'b0;
        end
      end
      S_INS_RD: begin
        cmd.op    = DP_INS_RD;
        state_nxt = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (!stat.pos_zero && !stat.use_q) begin
          status_nxt = ST_BAD;
          res_nxt    = RES_ERR;
          emit_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end else if (stat.free_empty) begin
          status_nxt = ST_FULL;
          res_nxt    = RES_ERR;
          emit_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.op    = DP_INS_WR1;
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.op     = DP_INS_WR2;
        status_nxt = ST_OK;
        res_nxt    = RES_INSERT;
        emit_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_REM_RD: begin
        cmd.op    = DP_REM_RD;
        state_nxt = S_REM_CHK;
      end
      S_REM_CHK: begin
        if (!stat.use_q) begin
          status_nxt = ST_BAD;
          res_nxt    = RES_ERR;
          emit_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.op    = DP_REM_WR1;
          state_nxt = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd.op     = DP_REM_WR2;
        status_nxt = ST_OK;
        res_nxt    = RES_REMOVE;
        emit_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_WALK: begin
        // one next link per cycle, then fetch the whole node
        if (stat.steps_zero) begin
          cmd.op     = DP_WALK_LAST;
          status_nxt = ST_OK;
          res_nxt    = RES_FIND;
          emit_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.op = DP_WALK_STEP;
        end
      end
      S_READ_RD: begin
        cmd.op    = DP_READ_RD;
        state_nxt = S_READ_CHK;
      end
      S_READ_CHK: begin
        status_nxt = stat.use_q ? ST_OK : ST_BAD;
        res_nxt    = stat.use_q ? RES_READ : RES_ERR;
        emit_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
        emit_nxt  = 1'b0;
      end
    endcase

    if (accept) begin
      cmd.op     = DP_LOAD;
      res_nxt    = RES_ERR;
      status_nxt = ST_OK;
      case (in_cmd)
        CMD_INSERT_BEFORE: begin
          if (stat.where_bad) begin
            status_nxt = ST_BAD;
            emit_nxt   = 1'b1;
          end else begin
            state_nxt = S_INS_RD;
          end
        end
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          state_nxt = S_INS_RD;
        end
        CMD_DELETE: begin
          if (stat.where_bad || stat.where_zero) begin
            status_nxt = ST_BAD;
            emit_nxt   = 1'b1;
          end else if (stat.count_zero) begin
            status_nxt = ST_EMPTY;
            emit_nxt   = 1'b1;
          end else begin
            state_nxt = S_REM_RD;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (stat.count_zero) begin
            status_nxt = ST_EMPTY;
            emit_nxt   = 1'b1;
          end else begin
            state_nxt = S_REM_RD;
          end
        end
        CMD_FIND_POSITION: begin
          if (stat.count_zero) begin
            status_nxt = ST_EMPTY;
            emit_nxt   = 1'b1;
          end else if (stat.where_ge_count) begin
            status_nxt = ST_BAD;
            emit_nxt   = 1'b1;
          end else begin
            state_nxt = S_WALK;
          end
        end
        CMD_READ_SLOT: begin
          if (stat.where_bad) begin
            status_nxt = ST_BAD;
            emit_nxt   = 1'b1;
          end else if (stat.where_zero) begin
            res_nxt  = RES_SENTINEL;
            emit_nxt = 1'b1;
          end else begin
            state_nxt = S_READ_RD;
          end
        end
        default: begin
          status_nxt = ST_BAD;
          emit_nxt   = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
      res_r       <= RES_ERR;
      status_r    <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
      status_r    <= status_nxt;
    end
  end

endmodule

### hw/rtl/alm_datapath.sv
`timescale 1ns / 1ps
// Node store, list registers and result register of the array linked list manager.
// Depends on alm_pkg; controlled by alm_ctrl through dp_cmd_t.
module alm_datapath #(
  parameter int CAPACITY    = alm_pkg::ALM_CAPACITY,
  parameter int VALUE_WIDTH = alm_pkg::ALM_VALUE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  alm_pkg::dp_cmd_t                cmd,
  output alm_pkg::dp_stat_t               stat,
  input  alm_pkg::cmd_t                   in_cmd,
  input  logic [alm_pkg::WHERE_W-1:0]     in_where,
  input  logic [alm_pkg::DATA_W-1:0]      in_value,
  output logic [alm_pkg::STATUS_W-1:0]    out_status,
  output logic [alm_pkg::FIELD_W-1:0]     out_slot,
  output logic [alm_pkg::DATA_W-1:0]      out_slot_value,
  output logic [alm_pkg::FIELD_W-1:0]     out_next_slot,
  output logic [alm_pkg::FIELD_W-1:0]     out_prev_slot,
  output logic [alm_pkg::FIELD_W-1:0]     out_front_slot,
  output logic [alm_pkg::FIELD_W-1:0]     out_back_slot,
  output logic [alm_pkg::FIELD_W-1:0]     out_count
);
  import alm_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [VALUE_WIDTH-1:0] val_t;

  function automatic logic [FIELD_W-1:0] slot_fld(input slot_t s);
    logic [SLOT_W+FIELD_W-1:0] w;
    begin
      w = {{FIELD_W{1'b0}}, s};
      return w[FIELD_W-1:0];
    end
  endfunction

  function automatic logic [DATA_W-1:0] val_fld(input val_t v);
    logic [VALUE_WIDTH+DATA_W-1:0] w;
    begin
      w = {{DATA_W{1'b0}}, v};
      return w[DATA_W-1:0];
    end
  endfunction

  // node store
  val_t  value_mem [CAPACITY];
  slot_t next_mem  [CAPACITY];
  slot_t prev_mem  [CAPACITY];
  logic  use_mem   [CAPACITY];

  logic  value_we, value_re, next_we, next_re, prev_we, prev_re, use_we, use_re;
  slot_t value_waddr, value_raddr, next_waddr, next_raddr;
  slot_t prev_waddr, prev_raddr, use_waddr, use_raddr;
  val_t  value_wdata;
  slot_t next_wdata, prev_wdata;
  logic  use_wdata;

  val_t  value_q;
  slot_t next_q, prev_q;
  logic  use_q;

  // list state
  slot_t front_r, back_r, free_head_r, count_r, clr_r;
  // item operands
  slot_t tgt_r, ins_slot_r, before_r, cur_r;
  val_t  v_r;
  logic [WHERE_W-1:0] steps_r;
  logic  first_r;

  logic [STATUS_W-1:0] out_status_r;
  logic [FIELD_W-1:0]  out_slot_r, out_next_r, out_prev_r;
  logic [FIELD_W-1:0]  out_front_r, out_back_r, out_count_r;
  logic [DATA_W-1:0]   out_value_r;

  logic [SLOT_W+WHERE_W-1:0]      where_ext, count_ext;
  logic [VALUE_WIDTH+DATA_W-1:0]  in_value_ext;
  slot_t where_slot, walk_addr, clr_link;
  val_t  in_val;

  assign where_ext    = {{SLOT_W{1'b0}}, in_where};
  assign count_ext    = {{WHERE_W{1'b0}}, count_r};
  assign where_slot   = where_ext[SLOT_W-1:0];
  assign in_value_ext = {{VALUE_WIDTH{1'b0}}, in_value};
  assign in_val       = in_value_ext[VALUE_WIDTH-1:0];
  assign walk_addr    = first_r ? front_r : next_q;
  // free chain at reset: slot i links to i+1, sentinel and last slot to 0
  assign clr_link     = ((clr_r == '0) || (clr_r == slot_t'(CAPACITY - 1))) ?
                        '0 : clr_r + slot_t'(1);

  assign stat.where_bad      = where_ext >= (SLOT_W + WHERE_W)'(CAPACITY);
  assign stat.where_zero     = (in_where == '0);
  assign stat.where_ge_count = where_ext >= count_ext;
  assign stat.count_zero     = (count_r == '0);
  assign stat.count_max      = (count_r == slot_t'(CAPACITY - 1));
  assign stat.free_empty     = (free_head_r == '0);
  assign stat.pos_zero       = (tgt_r == '0);
  assign stat.use_q          = use_q;
  assign stat.steps_zero     = (steps_r == '0);
  assign stat.clr_last       = (clr_r == slot_t'(CAPACITY - 1));

  always_comb begin
    value_we = 1'b0; value_waddr = '0; value_wdata = '0;
    next_we  = 1'b0; next_waddr  = '0; next_wdata  = '0;
    prev_we  = 1'b0; prev_waddr  = '0; prev_wdata  = '0;
    use_we   = 1'b0; use_waddr   = '0; use_wdata   = 1'b0;
    value_re = 1'b0; value_raddr = '0;
    next_re  = 1'b0; next_raddr  = '0;
    prev_re  = 1'b0; prev_raddr  = '0;
    use_re   = 1'b0; use_raddr   = '0;
    case (cmd.op)
      DP_CLEAR: begin
        next_we = 1'b1; next_waddr = clr_r; next_wdata = clr_link;
        prev_we = 1'b1; prev_waddr = clr_r;
        use_we  = 1'b1; use_waddr  = clr_r;
      end
      DP_INS_RD: begin
        next_re = 1'b1; next_raddr = free_head_r;
        prev_re = 1'b1; prev_raddr = tgt_r;
        use_re  = 1'b1; use_raddr  = tgt_r;
      end
      DP_INS_WR1: begin
        next_we  = 1'b1; next_waddr  = free_head_r; next_wdata  = tgt_r;
        prev_we  = 1'b1; prev_waddr  = free_head_r; prev_wdata  = prev_q;
        value_we = 1'b1; value_waddr = free_head_r; value_wdata = v_r;
        use_we   = 1'b1; use_waddr   = free_head_r; use_wdata   = 1'b1;
      end
      DP_INS_WR2: begin
        next_we = 1'b1; next_waddr = before_r; next_wdata = ins_slot_r;
        prev_we = 1'b1; prev_waddr = tgt_r;    prev_wdata = ins_slot_r;
      end
      DP_REM_RD, DP_READ_RD: begin
        value_re = 1'b1; value_raddr = tgt_r;
        next_re  = 1'b1; next_raddr  = tgt_r;
        prev_re  = 1'b1; prev_raddr  = tgt_r;
        use_re   = 1'b1; use_raddr   = tgt_r;
      end
      DP_REM_WR1: begin
        // unlink: neighbors point past the removed slot
        next_we = 1'b1; next_waddr = prev_q; next_wdata = next_q;
        prev_we = 1'b1; prev_waddr = next_q; prev_wdata = prev_q;
        use_we  = 1'b1; use_waddr  = tgt_r;
      end
      DP_REM_WR2: begin
        next_we = 1'b1; next_waddr = tgt_r; next_wdata = free_head_r;
        prev_we = 1'b1; prev_waddr = tgt_r;
      end
      DP_WALK_STEP: begin
        next_re = 1'b1; next_raddr = walk_addr;
      end
      DP_WALK_LAST: begin
        value_re = 1'b1; value_raddr = walk_addr;
        next_re  = 1'b1; next_raddr  = walk_addr;
        prev_re  = 1'b1; prev_raddr  = walk_addr;
        use_re   = 1'b1; use_raddr   = walk_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (value_we) value_mem[value_waddr] <= value_wdata;
    if (value_re) value_q <= value_mem[value_raddr];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (next_re) next_q <= next_mem[next_raddr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    if (prev_re) prev_q <= prev_mem[prev_raddr];
  end

  always_ff @(posedge clk) begin
    if (use_we) use_mem[use_waddr] <= use_wdata;
    if (use_re) use_q <= use_mem[use_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      back_r      <= '0;
      free_head_r <= slot_t'(1);
      count_r     <= '0;
      clr_r       <= '0;
    end else begin
      case (cmd.op)
        DP_CLEAR: begin
          clr_r <= clr_r + slot_t'(1);
        end
        DP_INS_WR1: begin
          free_head_r <= next_q;
          count_r     <= count_r + slot_t'(1);
        end
        DP_INS_WR2: begin
          if (before_r == '0) front_r <= ins_slot_r;
          if (tgt_r == '0) back_r <= ins_slot_r;
        end
        DP_REM_WR1: begin
          if (prev_q == '0) front_r <= next_q;
          if (next_q == '0) back_r <= prev_q;
        end
        DP_REM_WR2: begin
          free_head_r <= tgt_r;
          count_r     <= count_r - slot_t'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        v_r     <= in_val;
        steps_r <= in_where;
        first_r <= 1'b1;
        case (in_cmd)
          CMD_PUSH_FRONT, CMD_POP_FRONT: tgt_r <= front_r;
          CMD_PUSH_BACK:                 tgt_r <= '0;
          CMD_POP_BACK:                  tgt_r <= back_r;
          default:                       tgt_r <= where_slot;
        endcase
      end
      DP_INS_WR1: begin
        ins_slot_r <= free_head_r;
        before_r   <= prev_q;
      end
      DP_WALK_STEP: begin
        steps_r <= steps_r - WHERE_W'(1);
        first_r <= 1'b0;
      end
      DP_WALK_LAST: begin
        cur_r <= walk_addr;
      end
      default: begin
      end
    endcase
  end

  // result register: loaded once all list updates of the item are done
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.status;
      out_front_r  <= slot_fld(front_r);
      out_back_r   <= slot_fld(back_r);
      out_count_r  <= slot_fld(count_r);
      case (cmd.res)
        RES_INSERT: begin
          out_slot_r  <= slot_fld(ins_slot_r);
          out_value_r <= val_fld(v_r);
          out_next_r  <= slot_fld(tgt_r);
          out_prev_r  <= slot_fld(before_r);
        end
        RES_REMOVE, RES_READ: begin
          out_slot_r  <= slot_fld(tgt_r);
          out_value_r <= val_fld(value_q);
          out_next_r  <= slot_fld(next_q);
          out_prev_r  <= slot_fld(prev_q);
        end
        RES_FIND: begin
          out_slot_r  <= slot_fld(cur_r);
          out_value_r <= use_q ? val_fld(value_q) : '0;
          out_next_r  <= slot_fld(next_q);
          out_prev_r  <= slot_fld(prev_q);
        end
        RES_SENTINEL: begin
          out_slot_r  <= '0;
          out_value_r <= '0;
          out_next_r  <= slot_fld(front_r);
          out_prev_r  <= slot_fld(back_r);
        end
        default: begin
          out_slot_r  <= '0;
          out_value_r <= '0;
          out_next_r  <= '0;
          out_prev_r  <= '0;
        end
      endcase
    end
  end

  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_slot_value = out_value_r;
  assign out_next_slot  = out_next_r;
  assign out_prev_slot  = out_prev_r;
  assign out_front_slot = out_front_r;
  assign out_back_slot  = out_back_r;
  assign out_count      = out_count_r;

endmodule

### hw/rtl/array_linked_list_manager.sv
`timescale 1ns / 1ps
// Top level of the array linked list manager: controller plus datapath.
// Depends on alm_pkg, alm_ctrl and alm_datapath.
//
// A doubly linked list kept in a CAPACITY-slot node store, slot 0 being the
// sentinel and unused slots forming a free chain. One command word in gives
// one result word out. After reset the block sweeps the node store once,
// one slot per cycle, so in_stall stays high until the sweep is done. A
// word is worked off in full before the next one is taken. A find walks
// from the front, reading one next link per cycle from the single read port
// of the link memory; commands rejected on the spot (empty list, bad slot or
// position) need no node store access, and a failed insert or delete check
// ends after the node read. The next word is taken while the previous
// result still sits in the output register.
module array_linked_list_manager #(
  parameter int CAPACITY    = alm_pkg::ALM_CAPACITY,
  parameter int VALUE_WIDTH = alm_pkg::ALM_VALUE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [alm_pkg::CMD_W-1:0]    in_cmd,
  input  logic [alm_pkg::WHERE_W-1:0]  in_where,
  input  logic [alm_pkg::DATA_W-1:0]   in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [alm_pkg::STATUS_W-1:0] out_status,
  output logic [alm_pkg::FIELD_W-1:0]  out_slot,
  output logic [alm_pkg::DATA_W-1:0]   out_slot_value,
  output logic [alm_pkg::FIELD_W-1:0]  out_next_slot,
  output logic [alm_pkg::FIELD_W-1:0]  out_prev_slot,
  output logic [alm_pkg::FIELD_W-1:0]  out_front_slot,
  output logic [alm_pkg::FIELD_W-1:0]  out_back_slot,
  output logic [alm_pkg::FIELD_W-1:0]  out_count
);
  import alm_pkg::*;

  cmd_t     in_cmd_e;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign in_cmd_e = cmd_t'(in_cmd);

  alm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd_e),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  alm_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .in_cmd         (in_cmd_e),
    .in_where       (in_where),
    .in_value       (in_value),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_slot_value (out_slot_value),
    .out_next_slot  (out_next_slot),
    .out_prev_slot  (out_prev_slot),
    .out_front_slot (out_front_slot),
    .out_back_slot  (out_back_slot),
    .out_count      (out_count)
  );

  // free chain is empty exactly when every non-sentinel slot holds an element
  a_free_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    dp_stat.free_empty == dp_stat.count_max)
    else $error("free chain state disagrees with element count");

  // a failed command reports no slot
  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      (out_slot == '0) && (out_slot_value == '0) &&
      (out_next_slot == '0) && (out_prev_slot == '0))
    else $error("error result carries slot data");

  // empty status only ever comes from an empty list
  a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |->
      (out_count == '0) && (out_front_slot == '0) && (out_back_slot == '0))
    else $error("list empty reported on a non-empty list");

endmodule
